// ===== sv/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PLSIG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plsig assertion failed");

// next-cycle implication, checked out of reset
`define PLSIG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plsig assertion failed");

`endif

// ===== sv/plsig_pkg.sv =====
// constants, band tables and stage control type of the sigmoid pipeline
package plsig_pkg;

  localparam int X_W        = 32;
  localparam int FRAC_BITS  = 27;
  localparam int BAND_COUNT = 16;
  localparam int BAND_W     = $clog2(BAND_COUNT);
  localparam int SLOPE_W    = 29;
  localparam int BIAS_W     = 31;
  localparam int PROD_W     = X_W + SLOPE_W;
  localparam int SHIFT_W    = PROD_W - FRAC_BITS;
  localparam int SUM_W      = SHIFT_W + 2;

  // upper edge of each magnitude band
  localparam logic [X_W-1:0] BAND_EDGE [BAND_COUNT] = '{
    32'd63656107,  32'd111395083, 32'd153816608, 32'd194953701,
    32'd236865036, 32'd281253298, 32'd329433241, 32'd384154475,
    32'd447714743, 32'd515399149, 32'd589016819, 32'd679940425,
    32'd759830874, 32'd862986200, 32'd965402453, 32'd2147483648};

  // slope of each band
  localparam logic [SLOPE_W-1:0] BAND_SLOPE [BAND_COUNT] = '{
    29'd529475578, 29'd482862538, 29'd424212188, 29'd361565531,
    29'd298613704, 29'd238039992, 29'd181912633, 29'd132002182,
    29'd89144402,  29'd56020914,  29'd34019888,  29'd18928477,
    29'd9459126,   29'd5291645,   29'd2204341,   29'd177654};

  // bias for non-negative samples
  localparam logic [BIAS_W-1:0] BIAS_POS [BAND_COUNT] = '{
    31'd1073741824, 31'd1095849221, 31'd1144526551, 31'd1216321063,
    31'd1307759740, 31'd1414659140, 31'd1532274042, 31'd1654777693,
    31'd1777444109, 31'd1887935281, 31'd1972419725, 31'd2038648643,
    31'd2086619912, 31'd2110212774, 31'd2130063364, 31'd2144640936};

  // bias for negative samples
  localparam logic [BIAS_W-1:0] BIAS_NEG [BAND_COUNT] = '{
    31'd1073741824, 31'd1051634427, 31'd1002957097, 31'd931162585,
    31'd839723908,  31'd732824508,  31'd615209606,  31'd492705955,
    31'd370039539,  31'd259548367,  31'd175063923,  31'd108835005,
    31'd60863736,   31'd37270874,   31'd17420284,   31'd2842712};

  // control carried along with each word
  typedef struct packed {
    logic              valid;
    logic              neg;
    logic [BAND_W-1:0] band;
  } plsig_ctl_t;

endpackage

// ===== sv/piecewise_linear_sigmoid_q31.sv =====
// top level of the piecewise linear sigmoid, q4.27 in, q31 out
//
// Usage:
//   A sample is taken on in_x at every rising edge where start is high and
//   busy is low. busy is held low: the pipeline takes one word per cycle,
//   every cycle, with no gaps.
//   The result appears on out_y for exactly one cycle with out_valid high,
//   once the sample has passed the band, multiply and output registers.
//   Words leave in the order they came in.
//   Throughput is one word per cycle. There are three register stages:
//   band search, 29x32 multiply, then scale, bias and clamp.
//   The receiver has no way to hold results off and needs none: the
//   pipeline never stalls, so it must take out_y whenever out_valid is high.
//   A synchronous reset (rst_n low) clears all valid bits; words in flight
//   are dropped and no result is strobed until new samples arrive.
//   There are no configuration registers and no state between words.
`include "assert_macros.svh"

module piecewise_linear_sigmoid_q31 import plsig_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [X_W-1:0] in_x,
  output logic                  out_valid,
  output logic signed [X_W-1:0] out_y
);

  plsig_ctl_t        s1_ctl;
  plsig_ctl_t        s2_ctl;
  logic [X_W-1:0]    s1_mag;
  logic [PROD_W-1:0] s2_prod;
  logic              in_fire;

  // always ready for a new word
  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // band search
  plsig_band u_band (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_fire),
    .x        (in_x),
    .ctl_o    (s1_ctl),
    .mag_r    (s1_mag)
  );

  // multiply
  plsig_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (s1_ctl),
    .mag_i  (s1_mag),
    .ctl_o  (s2_ctl),
    .prod_r (s2_prod)
  );

  // scale, bias and clamp
  plsig_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (s2_ctl),
    .prod_i  (s2_prod),
    .valid_r (out_valid),
    .y_r     (out_y)
  );

  // every accepted word reaches the output
  `PLSIG_ASSERT_NOW(a_lat_word, in_fire, ##3 out_valid)
  // no result without an earlier accepted sample
  `PLSIG_ASSERT_NOW(a_lat_none, !in_fire, ##3 !out_valid)
  // valid bits move one stage per cycle
  `PLSIG_ASSERT_NEXT(a_s1_to_s2, s1_ctl.valid, s2_ctl.valid)

endmodule

// ===== sv/plsig_band.sv =====
// stage one: magnitude of the sample and band search
module plsig_band import plsig_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic signed [X_W-1:0] x,
  output plsig_ctl_t            ctl_o,
  output logic [X_W-1:0]        mag_r
);

  logic                  valid_r;
  logic                  neg_r;
  logic [BAND_W-1:0]     band_r;
  logic                  neg_nxt;
  logic [X_W-1:0]        mag_nxt;
  logic [BAND_W-1:0]     band_nxt;
  logic [BAND_COUNT-2:0] hit;

  // absolute value; the most negative sample maps to 2^31 unsigned
  always_comb begin
    neg_nxt = x[X_W-1];
    mag_nxt = neg_nxt ? (~unsigned'(x) + X_W'(1)) : unsigned'(x);
  end

  // compare against all edges but the last at once, then take the first hit; the last band is the default
  always_comb begin
    for (int k = 0; k < BAND_COUNT - 1; k++) begin
      hit[k] = (mag_nxt <= BAND_EDGE[k]);
    end
    band_nxt = BAND_W'(BAND_COUNT - 1);
    for (int k = BAND_COUNT - 2; k >= 0; k--) begin
      if (hit[k]) begin
        band_nxt = BAND_W'(k);
      end
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    band_r <= band_nxt;
    mag_r  <= mag_nxt;
  end

  assign ctl_o = '{valid: valid_r, neg: neg_r, band: band_r};

endmodule

// ===== sv/plsig_mul.sv =====
// stage two: slope times magnitude
module plsig_mul import plsig_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  plsig_ctl_t        ctl_i,
  input  logic [X_W-1:0]    mag_i,
  output plsig_ctl_t        ctl_o,
  output logic [PROD_W-1:0] prod_r
);

  logic              valid_r;
  logic              neg_r;
  logic [BAND_W-1:0] band_r;
  logic [PROD_W-1:0] prod_nxt;

  // unsigned product, below 2^61
  assign prod_nxt = PROD_W'(BAND_SLOPE[ctl_i.band]) * PROD_W'(mag_i);

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    neg_r  <= ctl_i.neg;
    band_r <= ctl_i.band;
    prod_r <= prod_nxt;
  end

  assign ctl_o = '{valid: valid_r, neg: neg_r, band: band_r};

endmodule

// ===== sv/plsig_out.sv =====
// stage three: scaling, bias add and saturation
module plsig_out import plsig_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  plsig_ctl_t            ctl_i,
  input  logic [PROD_W-1:0]     prod_i,
  output logic                  valid_r,
  output logic signed [X_W-1:0] y_r
);

  logic [SHIFT_W-1:0]       q_floor;
  logic                     frac_nz;
  logic [SHIFT_W:0]         q_ceil;
  logic [BIAS_W-1:0]        bias;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-X_W:0]       top_bits;
  logic signed [X_W-1:0]    y_nxt;

  // floor for positive products, ceiling for products that get negated
  always_comb begin
    q_floor = prod_i[PROD_W-1:FRAC_BITS];
    frac_nz = |prod_i[FRAC_BITS-1:0];
    q_ceil  = (SHIFT_W+1)'(q_floor) + (SHIFT_W+1)'(frac_nz);
    bias    = ctl_i.neg ? BIAS_NEG[ctl_i.band] : BIAS_POS[ctl_i.band];
  end

  // bias plus signed scaled product
  always_comb begin
    if (ctl_i.neg) begin
      sum = signed'(SUM_W'(bias)) - signed'(SUM_W'(q_ceil));
    end else begin
      sum = signed'(SUM_W'(bias)) + signed'(SUM_W'(q_floor));
    end
  end

  // clamp to signed 32 bits
  always_comb begin
    top_bits = sum[SUM_W-1:X_W-1];
    if (!sum[SUM_W-1] && (|top_bits)) begin
      y_nxt = {1'b0, {(X_W-1){1'b1}}};
    end else if (sum[SUM_W-1] && !(&top_bits)) begin
      y_nxt = {1'b1, {(X_W-1){1'b0}}};
    end else begin
      y_nxt = sum[X_W-1:0];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    y_r <= y_nxt;
  end

endmodule
